>>> hdl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque files.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int ACT_W = 3;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;

    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
    localparam logic [VAL_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;

    typedef enum logic [ACT_W-1:0] {
        ACT_PUSH_FRONT = 3'd0,
        ACT_PUSH_BACK  = 3'd1,
        ACT_POP_FRONT  = 3'd2,
        ACT_POP_BACK   = 3'd3,
        ACT_QUERY      = 3'd4
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
        logic read;
    } t_cmd;

endpackage

>>> hdl/bdq_if.sv
// ----------------------------------------------------------------------------
// bdq_if
// Valid/ready channels of the bounded deque: configuration, request, result.
// ----------------------------------------------------------------------------
interface bdq_cfg_if import bdq_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

interface bdq_req_if import bdq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic        [ACT_W-1:0] action;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface bdq_rsp_if import bdq_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    ok;
    logic signed [VAL_W-1:0] front_value;
    logic signed [VAL_W-1:0] rear_value;
    logic                    has_items;
    logic                    is_empty;
    logic                    is_full;

    modport source (output valid, output ok, output front_value, output rear_value,
                    output has_items, output is_empty, output is_full, input ready);
    modport sink   (input valid, input ok, input front_value, input rear_value,
                    input has_items, input is_empty, input is_full, output ready);
endinterface

>>> hdl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

>>> hdl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// Sequencer: capture item, update state, read front/rear, present result.
// ----------------------------------------------------------------------------
module bdq_ctrl import bdq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_EXEC;
            end
            ST_EXEC: n_state = ST_READ;
            ST_READ: n_state = ST_RESP;
            ST_RESP: begin
                if (i_out_ready) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            ST_EXEC: o_cmd.exec = 1'b1;
            ST_READ: o_cmd.read = 1'b1;
            ST_RESP: o_out_valid = 1'b1;
            default: o_cmd = '0;
        endcase
    end

`ifndef SYNTHESIS
    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("captured item not executed next cycle");

    a_exec_then_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_cmd.read)
        else $error("state update not followed by read");

    a_read_then_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.read |=> o_out_valid)
        else $error("read not followed by result");

    a_one_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_in_ready, o_cmd.exec, o_cmd.read, o_out_valid}))
        else $error("overlapping sequencer phases");
`endif

endmodule

>>> hdl/bdq_dpath.sv
// ----------------------------------------------------------------------------
// bdq_dpath
// Ring buffer datapath: head pointer, count, capacity, entry RAM, result.
// ----------------------------------------------------------------------------
module bdq_dpath import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic                    i_cfg_we,
    input  logic        [CAP_W-1:0] i_cfg_capacity,
    input  logic        [ACT_W-1:0] i_action,
    input  logic signed [VAL_W-1:0] i_value,
    output logic                    o_ok,
    output logic signed [VAL_W-1:0] o_front_value,
    output logic signed [VAL_W-1:0] o_rear_value,
    output logic                    o_has_items,
    output logic                    o_is_empty,
    output logic                    o_is_full
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int MW = (CW > CAP_W) ? CW : CAP_W;
    localparam int SW = ((AW > CW) ? AW : CW) + 1;

    t_action          r_action;
    logic [VAL_W-1:0] r_value;
    logic [AW-1:0]    r_head;
    logic [AW-1:0]    n_head;
    logic [CW-1:0]    r_count;
    logic [CW-1:0]    n_count;
    logic [CAP_W-1:0] r_capacity;
    logic             r_ok;
    logic             n_ok;

    logic [MW-1:0]    cap_ext;
    logic [MW-1:0]    eff_cap;
    logic             full;
    logic             has_items;
    logic [AW-1:0]    head_dec;
    logic [AW-1:0]    head_inc;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    rear_addr;
    logic [VAL_W-1:0] rdata_front;
    logic [VAL_W-1:0] rdata_rear;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] offs);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(offs);
        if (sum >= SW'(DEPTH)) sum = sum - SW'(DEPTH);
        return sum[AW-1:0];
    endfunction

    assign cap_ext   = MW'(r_capacity);
    assign eff_cap   = (cap_ext > MW'(DEPTH)) ? MW'(DEPTH) : cap_ext;
    assign full      = MW'(r_count) >= eff_cap;
    assign has_items = r_count != '0;
    assign head_dec  = (r_head == '0) ? AW'(DEPTH - 1) : r_head - AW'(1);
    assign head_inc  = (r_head == AW'(DEPTH - 1)) ? '0 : r_head + AW'(1);
    assign rear_addr = ring_add(r_head, r_count - CW'(1));

    always_comb begin
        n_head    = r_head;
        n_count   = r_count;
        n_ok      = 1'b1;
        ram_we    = 1'b0;
        ram_waddr = head_dec;
        unique case (r_action)
            ACT_PUSH_FRONT: begin
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = head_dec;
                    n_count = r_count + CW'(1);
                    ram_we  = 1'b1;
                end
            end
            ACT_PUSH_BACK: begin
                ram_waddr = ring_add(r_head, r_count);
                if (full) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count + CW'(1);
                    ram_we  = 1'b1;
                end
            end
            ACT_POP_FRONT: begin
                if (!has_items) begin
                    n_ok = 1'b0;
                end else begin
                    n_head  = head_inc;
                    n_count = r_count - CW'(1);
                end
            end
            ACT_POP_BACK: begin
                if (!has_items) begin
                    n_ok = 1'b0;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            default: n_ok = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_count    <= '0;
            r_capacity <= CAP_RESET;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_capacity;
            end
            if (i_cmd.exec) begin
                r_head  <= n_head;
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= t_action'(i_action);
            r_value  <= i_value;
        end
        if (i_cmd.exec) begin
            r_ok <= n_ok;
        end
    end

    bdq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (i_cmd.exec & ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (r_value),
        .i_re      (i_cmd.read),
        .i_raddr_a (r_head),
        .i_raddr_b (rear_addr),
        .o_rdata_a (rdata_front),
        .o_rdata_b (rdata_rear)
    );

    assign o_ok          = r_ok;
    assign o_front_value = has_items ? rdata_front : EMPTY_VALUE;
    assign o_rear_value  = has_items ? rdata_rear : EMPTY_VALUE;
    assign o_has_items   = has_items;
    assign o_is_empty    = !has_items;
    assign o_is_full     = full;

endmodule

>>> hdl/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// Double-ended queue of signed 32-bit values in a ring buffer, capacity set
// by a configuration register.
//
//   channel  dir  handshake    payload
//   i_cfg    in   valid/ready  capacity[4:0]
//   i_req    in   valid/ready  action[2:0], value[31:0]
//   o_rsp    out  valid/ready  ok, front_value, rear_value, has_items,
//                              is_empty, is_full
//
// One item at a time, in the sequence capture, update plus RAM write,
// registered RAM read of front and rear, result.
// A stall on o_rsp holds the block; i_req.ready stays low until the result
// is taken. i_cfg is always ready.
// Reset clears head, count and sets capacity to 16; the entry RAM is not
// cleared.
// ----------------------------------------------------------------------------
module bounded_deque import bdq_pkg::*; #(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bdq_cfg_if.sink   i_cfg,
    bdq_req_if.sink   i_req,
    bdq_rsp_if.source o_rsp
);

    t_cmd cmd;

    assign i_cfg.ready = 1'b1;

    bdq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    bdq_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_cfg_we       (i_cfg.valid),
        .i_cfg_capacity (i_cfg.capacity),
        .i_action       (i_req.action),
        .i_value        (i_req.value),
        .o_ok           (o_rsp.ok),
        .o_front_value  (o_rsp.front_value),
        .o_rear_value   (o_rsp.rear_value),
        .o_has_items    (o_rsp.has_items),
        .o_is_empty     (o_rsp.is_empty),
        .o_is_full      (o_rsp.is_full)
    );

endmodule
